// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/pip_pkg.sv
// Package: constants, types and helpers of the point-in-polygon tester.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int VIDX_W       = 6;
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DET_W        = PROD_W + 2;
  localparam int VCNT_W       = 7;
  localparam int TOL_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 1'b1;

  localparam logic ACT_VERTEX = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  localparam logic [VCNT_W-1:0]         VCNT_RESET = '0;
  localparam logic [TOL_W-1:0]          TOL_RESET  = 16'd66;
  // 10000.0 in Q15.8
  localparam logic signed [COORD_W-1:0] RAY_TOP_Y  = 24'sd2560000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef struct packed {
    logic busy;
  } back_status_t;

  function automatic logic signed [DIFF_W-1:0] sub_c(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] ae;
    logic signed [DIFF_W-1:0] be;
    ae = {a[COORD_W-1], a};
    be = {b[COORD_W-1], b};
    return ae - be;
  endfunction

endpackage

// File: sv/pip_if.sv
// Interfaces: input and result channels with valid/ready handshake.
interface pip_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [pip_pkg::VIDX_W-1:0]          vertex_index;
  logic signed [pip_pkg::COORD_W-1:0]  coord_x;
  logic signed [pip_pkg::COORD_W-1:0]  coord_y;

  modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_edge;

  modport source (output valid, inside_res, on_edge, input ready);
  modport sink   (input valid, inside_res, on_edge, output ready);
endinterface

// File: sv/pip_ram.sv
// Generic single write port RAM with one registered read port.
module pip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/pip_fifo.sv
// Short query queue between front and back.
module pip_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pip_pkg::point_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pip_pkg::point_t pop_data_o,
  output logic            empty_o
);
  localparam int PTR_W = $clog2(pip_pkg::QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(pip_pkg::QUEUE_DEPTH + 1);

  pip_pkg::point_t    mem_q [pip_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(pip_pkg::QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule

// File: sv/pip_front.sv
// Front end: accepts transactions, writes vertices, queues query points.
module pip_front (
  pip_in_if.sink                        in_if,
  input  pip_pkg::back_status_t         status_i,
  input  logic                          q_full_i,
  input  logic                          q_empty_i,
  output logic                          push_o,
  output pip_pkg::point_t               push_data_o,
  output logic                          ram_we_o,
  output logic [pip_pkg::ADDR_W-1:0]    ram_waddr_o,
  output logic [pip_pkg::POINT_W-1:0]   ram_wdata_o
);
  logic            is_query;
  logic            accept;
  pip_pkg::point_t pt;

  assign is_query = (in_if.action == pip_pkg::ACT_QUERY);
  // vertex writes wait until no query is pending so a walk sees a stable store
  assign in_if.ready = is_query ? !q_full_i : (!status_i.busy && q_empty_i);
  assign accept      = in_if.valid && in_if.ready;

  assign pt.x = in_if.coord_x;
  assign pt.y = in_if.coord_y;

  assign push_o      = accept && is_query;
  assign push_data_o = pt;
  assign ram_we_o    = accept && !is_query &&
                       ({1'b0, in_if.vertex_index} < (pip_pkg::VIDX_W + 1)'(pip_pkg::MAX_VERTICES));
  assign ram_waddr_o = in_if.vertex_index[pip_pkg::ADDR_W-1:0];
  assign ram_wdata_o = pt;
endmodule

// File: sv/pip_back.sv
// Back end: walks the polygon edges one per cycle and forms the result.
module pip_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  pip_pkg::point_t               q_data_i,
  output logic                          pop_o,
  input  logic [pip_pkg::VCNT_W-1:0]    vertex_count_i,
  input  logic [pip_pkg::TOL_W-1:0]     tol_i,
  output logic                          ram_re_o,
  output logic [pip_pkg::ADDR_W-1:0]    ram_raddr_o,
  input  logic [pip_pkg::POINT_W-1:0]   ram_rdata_i,
  output pip_pkg::back_status_t         status_o,
  pip_out_if.source                     out_if
);
  localparam int CW = pip_pkg::CNT_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;
  localparam int TW = pip_pkg::DET_W;

  // query context
  pip_pkg::point_t                   p_q;
  logic signed [DW-1:0]              tpy_q;
  logic signed [pip_pkg::COORD_W-1:0] ylo_q, yhi_q;
  logic [CW-1:0]                     n_q, iss_q;
  logic                              run_q;

  // stage A: read data back from the store
  logic                              sa_vld_q, sa_first_q, sa_wrap_q;
  pip_pkg::point_t                   v0_q, prev_q;

  // stage B: differences and box tests
  logic                              sb_vld_q, sb_last_q, sb_box_q, sb_span_q;
  logic signed [DW-1:0]              dax_q, dby_q, dbx_q, day_q, dbax_q;

  // stage C: products
  logic                              sc_vld_q, sc_last_q, sc_box_q, sc_span_q;
  logic signed [PW-1:0]              m1_q, m2_q, m3_q;

  // stage D: determinant
  logic                              sd_vld_q, sd_last_q, sd_box_q, sd_span_q;
  logic signed [TW-1:0]              det_q, m3x_q;

  logic                              on_acc_q, par_q;
  logic                              out_vld_q, inside_q, on_edge_q;

  logic                              start, busy;
  logic [CW-1:0]                     n_clamp;
  pip_pkg::point_t                   rd, a_pt, b_pt;
  logic signed [TW-1:0]              z, tol_s;
  logic                              near, on_e, xing;
  logic                              xrej, yrej;

  assign busy       = run_q || sa_vld_q || sb_vld_q || sc_vld_q || sd_vld_q;
  assign status_o.busy = busy;
  assign start      = !busy && !out_vld_q && !q_empty_i;
  assign pop_o      = start;
  assign n_clamp    = (vertex_count_i > pip_pkg::VCNT_W'(pip_pkg::MAX_VERTICES)) ?
                      CW'(pip_pkg::MAX_VERTICES) : CW'(vertex_count_i);

  assign ram_re_o    = run_q && (iss_q < n_q);
  assign ram_raddr_o = iss_q[pip_pkg::ADDR_W-1:0];

  assign rd   = pip_pkg::point_t'(ram_rdata_i);
  assign a_pt = prev_q;
  assign b_pt = sa_wrap_q ? v0_q : rd;

  // segment from the point to the ray top misses the edge's box
  assign xrej = ($signed(a_pt.x) > $signed(p_q.x) && $signed(b_pt.x) > $signed(p_q.x)) ||
                ($signed(a_pt.x) < $signed(p_q.x) && $signed(b_pt.x) < $signed(p_q.x));
  assign yrej = ($signed(a_pt.y) > yhi_q && $signed(b_pt.y) > yhi_q) ||
                ($signed(a_pt.y) < ylo_q && $signed(b_pt.y) < ylo_q);

  assign z     = det_q + m3x_q;
  assign tol_s = $signed(TW'(tol_i));
  assign near  = (det_q < tol_s) && (det_q > -tol_s);
  assign on_e  = near && sd_box_q;
  assign xing  = sd_span_q && !((det_q > 0 && z > 0) || (det_q < 0 && z < 0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      iss_q      <= '0;
      n_q        <= '0;
      sa_vld_q   <= 1'b0;
      sa_first_q <= 1'b0;
      sa_wrap_q  <= 1'b0;
      sb_vld_q   <= 1'b0;
      sb_last_q  <= 1'b0;
      sc_vld_q   <= 1'b0;
      sc_last_q  <= 1'b0;
      sd_vld_q   <= 1'b0;
      sd_last_q  <= 1'b0;
      on_acc_q   <= 1'b0;
      par_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      inside_q   <= 1'b0;
      on_edge_q  <= 1'b0;
    end else begin
      if (out_vld_q && out_if.ready) begin
        out_vld_q <= 1'b0;
      end

      if (start) begin
        n_q      <= n_clamp;
        iss_q    <= '0;
        run_q    <= (n_clamp != '0);
        on_acc_q <= 1'b0;
        par_q    <= 1'b0;
        if (n_clamp == '0) begin
          out_vld_q <= 1'b1;
          inside_q  <= 1'b0;
          on_edge_q <= 1'b0;
        end
      end else if (run_q) begin
        iss_q <= iss_q + 1'b1;
        if (iss_q == n_q) begin
          run_q <= 1'b0;
        end
      end

      sa_vld_q   <= run_q;
      sa_first_q <= (iss_q == '0);
      sa_wrap_q  <= (iss_q == n_q);

      sb_vld_q  <= sa_vld_q && !sa_first_q;
      sb_last_q <= sa_wrap_q;
      sc_vld_q  <= sb_vld_q;
      sc_last_q <= sb_last_q;
      sd_vld_q  <= sc_vld_q;
      sd_last_q <= sc_last_q;

      if (sd_vld_q) begin
        on_acc_q <= on_acc_q || on_e;
        par_q    <= par_q ^ xing;
        if (sd_last_q) begin
          out_vld_q <= 1'b1;
          on_edge_q <= on_acc_q || on_e;
          inside_q  <= on_acc_q || on_e || (par_q ^ xing);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      p_q   <= q_data_i;
      tpy_q <= pip_pkg::sub_c(pip_pkg::RAY_TOP_Y, q_data_i.y);
      if ($signed(q_data_i.y) < pip_pkg::RAY_TOP_Y) begin
        ylo_q <= q_data_i.y;
        yhi_q <= pip_pkg::RAY_TOP_Y;
      end else begin
        ylo_q <= pip_pkg::RAY_TOP_Y;
        yhi_q <= q_data_i.y;
      end
    end

    if (sa_vld_q) begin
      if (sa_first_q) begin
        v0_q   <= rd;
        prev_q <= rd;
      end else begin
        prev_q <= b_pt;
      end
    end

    dax_q     <= pip_pkg::sub_c(a_pt.x, p_q.x);
    dby_q     <= pip_pkg::sub_c(b_pt.y, p_q.y);
    dbx_q     <= pip_pkg::sub_c(b_pt.x, p_q.x);
    day_q     <= pip_pkg::sub_c(a_pt.y, p_q.y);
    dbax_q    <= pip_pkg::sub_c(b_pt.x, a_pt.x);
    sb_span_q <= !xrej && !yrej;
    sb_box_q  <= !xrej &&
                 !(($signed(a_pt.y) > $signed(p_q.y) && $signed(b_pt.y) > $signed(p_q.y)) ||
                   ($signed(a_pt.y) < $signed(p_q.y) && $signed(b_pt.y) < $signed(p_q.y)));

    m1_q      <= dax_q * dby_q;
    m2_q      <= dbx_q * day_q;
    m3_q      <= dbax_q * tpy_q;
    sc_box_q  <= sb_box_q;
    sc_span_q <= sb_span_q;

    det_q     <= TW'(m1_q) - TW'(m2_q);
    m3x_q     <= TW'(m3_q);
    sd_box_q  <= sc_box_q;
    sd_span_q <= sc_span_q;
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.inside_res = inside_q;
  assign out_if.on_edge    = on_edge_q;
endmodule

// File: sv/point_in_polygon_test_top.sv
// Point-in-polygon tester: the walk reads one edge per cycle through the single read
// port of the vertex store. A queued query starts in the cycle after the previous
// result is taken. Vertex writes wait while a query is queued or walking. Reset
// clears control and registers (count 0, tolerance 66), not the store.
module point_in_polygon_test_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pip_in_if.sink                             in_if,
  pip_out_if.source                          out_if,
  input  logic                               cfg_we_i,
  input  logic [pip_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pip_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  logic [pip_pkg::VCNT_W-1:0]   vcnt_q;
  logic [pip_pkg::TOL_W-1:0]    tol_q;

  pip_pkg::back_status_t        status;
  logic                         q_full, q_empty, push, pop;
  pip_pkg::point_t              push_data, pop_data;
  logic                         ram_we, ram_re;
  logic [pip_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [pip_pkg::POINT_W-1:0]  ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= pip_pkg::VCNT_RESET;
      tol_q  <= pip_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pip_pkg::CFG_VERTEX_COUNT: vcnt_q <= cfg_wdata_i[pip_pkg::VCNT_W-1:0];
        pip_pkg::CFG_TOLERANCE:    tol_q  <= cfg_wdata_i[pip_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  pip_front u_front (
    .in_if       (in_if),
    .status_i    (status),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .push_o      (push),
    .push_data_o (push_data),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  pip_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  pip_ram #(
    .WIDTH (pip_pkg::POINT_W),
    .DEPTH (pip_pkg::MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pip_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (pop_data),
    .pop_o          (pop),
    .vertex_count_i (vcnt_q),
    .tol_i          (tol_q),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .status_o       (status),
    .out_if         (out_if)
  );
endmodule

// File: sv/pip_checker.sv
// Checker on the top level ports, bound to the top level.
`include "assert_macros.svh"

module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_action_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_inside_i,
  input logic out_on_edge_i
);
  `PIP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `PIP_ASSERT(a_edge_inside, out_valid_i && out_on_edge_i |-> out_inside_i, "on edge but not inside")
  `PIP_ASSERT(a_write_idle, in_valid_i && in_ready_i && (in_action_i == pip_pkg::ACT_VERTEX) |=> !$rose(out_valid_i), "vertex write taken during a walk")
endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_action_i   (in_if.action),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_inside_i  (out_if.inside_res),
  .out_on_edge_i (out_if.on_edge)
);

// File: verif/tb_top.sv
// Testbench for the point-in-polygon tester: predicts every query result and checks it.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic                               action;
    logic [pip_pkg::VIDX_W-1:0]         vidx;
    logic signed [pip_pkg::COORD_W-1:0] x;
    logic signed [pip_pkg::COORD_W-1:0] y;
  } pip_item_t;

  typedef struct {
    logic in_poly;
    logic on_edge;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pip_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pip_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  pip_in_if  in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  pip_item_t pending_items[$];
  verdict_t  verdicts_due[$];
  pip_item_t cur_item;
  bit        in_took;
  int        errors;
  int        n_queries, n_writes, n_checked, n_phases;

  // polygon model
  pip_pkg::point_t            poly_store [pip_pkg::MAX_VERTICES];
  logic [pip_pkg::VCNT_W-1:0] poly_count;
  logic [pip_pkg::TOL_W-1:0]  poly_tol;

  // generator's view
  longint gen_x [pip_pkg::MAX_VERTICES];
  longint gen_y [pip_pkg::MAX_VERTICES];
  int     gen_n;
  longint win_cx, win_cy, win_span;

  function automatic longint cross_z(longint ox, longint oy, longint ax, longint ay,
                                     longint bx, longint by);
    return (ax - ox) * (by - oy) - (bx - ox) * (ay - oy);
  endfunction

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic verdict_t classify_point(longint px, longint py);
    verdict_t r;
    int n, j, hits;
    longint ax, ay, bx, by, d, ty;
    bit xing;
    r.in_poly = 1'b0;
    r.on_edge = 1'b0;
    hits = 0;
    ty = longint'(pip_pkg::RAY_TOP_Y);
    n = (poly_count > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : int'(poly_count);
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      ax = longint'(poly_store[i].x);
      ay = longint'(poly_store[i].y);
      bx = longint'(poly_store[j].x);
      by = longint'(poly_store[j].y);
      d = cross_z(px, py, ax, ay, bx, by);
      if (d < 0) d = -d;
      if (d < longint'(poly_tol) && px >= lmin(ax, bx) && px <= lmax(ax, bx) &&
          py >= lmin(ay, by) && py <= lmax(ay, by)) begin
        r.in_poly = 1'b1;
        r.on_edge = 1'b1;
        return r;
      end
      xing = 1'b1;
      if (lmax(px, px) < lmin(ax, bx) || lmax(ax, bx) < lmin(px, px) ||
          lmax(py, ty) < lmin(ay, by) || lmax(ay, by) < lmin(py, ty))
        xing = 1'b0;
      else if (!((sgn(cross_z(px, py, px, ty, ax, ay)) *
                  sgn(cross_z(px, py, px, ty, bx, by)) <= 0) &&
                 (sgn(cross_z(ax, ay, bx, by, px, py)) *
                  sgn(cross_z(ax, ay, bx, by, px, ty)) <= 0)))
        xing = 1'b0;
      if (xing) hits++;
    end
    r.in_poly = hits[0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic want, logic got);
    $display("ERROR %0t: %s expected %b got %b", $realtime, what, want, got);
    errors++;
  endtask

  // input side: bursts and gaps
  int burst_left = 5;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.action       <= cur_item.action;
        in_ch.vertex_index <= cur_item.vidx;
        in_ch.coord_x      <= cur_item.x;
        in_ch.coord_y      <= cur_item.y;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    in_took = in_ch.valid && in_ch.ready && rst_ni;
    if (in_took) begin
      if (cur_item.action == pip_pkg::ACT_VERTEX) begin
        poly_store[cur_item.vidx].x = cur_item.x;
        poly_store[cur_item.vidx].y = cur_item.y;
        n_writes++;
      end else begin
        verdicts_due.push_back(classify_point(longint'(cur_item.x), longint'(cur_item.y)));
        n_queries++;
      end
    end
  end

  // result side: ready cycles through four stall patterns
  int unsigned cyc;
  always @(negedge clk_i) begin
    cyc++;
    case ((cyc >> 8) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: out_ch.ready <= ((cyc % 7) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("result with no query outstanding", 1'b0, 1'b1);
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.inside_res !== want.in_poly)
          report_mismatch("inside_res", want.in_poly, out_ch.inside_res);
        if (out_ch.on_edge !== want.on_edge)
          report_mismatch("on_edge", want.on_edge, out_ch.on_edge);
        n_checked++;
      end
    end
  end

  function automatic logic signed [pip_pkg::COORD_W-1:0] clamp24(longint v);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[pip_pkg::COORD_W-1:0];
  endfunction

  function automatic longint rnd_span(longint c, longint s);
    return c - s + longint'($urandom_range(0, 2 * s));
  endfunction

  task automatic push_item(logic act, int slot, longint x, longint y);
    pip_item_t it;
    it.action = act;
    it.vidx = slot[pip_pkg::VIDX_W-1:0];
    it.x = clamp24(x);
    it.y = clamp24(y);
    pending_items.push_back(it);
  endtask

  task automatic put_vertex(int slot, longint x, longint y);
    push_item(pip_pkg::ACT_VERTEX, slot, x, y);
    gen_x[slot] = longint'(clamp24(x));
    gen_y[slot] = longint'(clamp24(y));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || verdicts_due.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [pip_pkg::CFG_IDX_W-1:0] idx,
                           logic [pip_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    if (idx == pip_pkg::CFG_VERTEX_COUNT) poly_count = data[pip_pkg::VCNT_W-1:0];
    else poly_tol = data[pip_pkg::TOL_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic push_query();
    int i, j;
    longint x, y;
    i = (gen_n > 0) ? $urandom_range(0, gen_n - 1) : 0;
    j = (i + 1 < gen_n) ? i + 1 : 0;
    x = rnd_span(win_cx, win_span);
    y = rnd_span(win_cy, win_span);
    if (gen_n > 0) begin
      case ($urandom_range(0, 9))
        4: begin x = gen_x[i]; y = gen_y[i]; end
        5: begin x = (gen_x[i] + gen_x[j]) >>> 1; y = (gen_y[i] + gen_y[j]) >>> 1; end
        6: begin
          x = gen_x[i] + $urandom_range(0, 2) - 1;
          y = gen_y[i] + $urandom_range(0, 2) - 1;
        end
        7: begin x = longint'($signed($urandom) >>> 8); y = longint'($signed($urandom) >>> 8); end
        8: begin
          x = $urandom_range(0, 1) ? 8388607 : -8388608;
          y = $urandom_range(0, 1) ? 8388607 : -8388608;
        end
        9: y = 2560001 + $urandom_range(0, 5828606);
        default: ;
      endcase
    end
    push_item(pip_pkg::ACT_QUERY, $urandom_range(0, 63), x, y);
  endtask

  initial begin
    int cnt, nq;
    logic [pip_pkg::TOL_W-1:0] tol;
    errors = 0;
    poly_count = pip_pkg::VCNT_RESET;
    poly_tol = pip_pkg::TOL_RESET;
    in_ch.valid = 1'b0;
    in_ch.action = pip_pkg::ACT_VERTEX;
    in_ch.vertex_index = '0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty polygon, triangle, degenerate polygons, extremes
    push_item(pip_pkg::ACT_QUERY, 0, 0, 0);
    drain();
    put_vertex(0, 0, 0);
    put_vertex(1, 2560, 0);
    put_vertex(2, 0, 2560);
    drain();
    cfg_write(pip_pkg::CFG_VERTEX_COUNT, 16'd3);
    push_item(pip_pkg::ACT_QUERY, 0, 256, 256);
    push_item(pip_pkg::ACT_QUERY, 0, 5000, 5000);
    push_item(pip_pkg::ACT_QUERY, 0, 1280, 0);
    push_item(pip_pkg::ACT_QUERY, 0, 0, 0);
    push_item(pip_pkg::ACT_QUERY, 0, 1280, 1280);
    push_item(pip_pkg::ACT_QUERY, 0, 256, 3000000);
    push_item(pip_pkg::ACT_QUERY, 63, -8388608, -8388608);
    push_item(pip_pkg::ACT_QUERY, 63, 8388607, 8388607);
    push_item(pip_pkg::ACT_QUERY, 0, 100, -1);
    drain();
    cfg_write(pip_pkg::CFG_VERTEX_COUNT, 16'd1);
    push_item(pip_pkg::ACT_QUERY, 0, 0, 0);
    push_item(pip_pkg::ACT_QUERY, 0, 0, -5);
    drain();
    cfg_write(pip_pkg::CFG_VERTEX_COUNT, 16'd2);
    push_item(pip_pkg::ACT_QUERY, 0, 1280, 0);
    push_item(pip_pkg::ACT_QUERY, 0, 1280, -10);
    drain();
    cfg_write(pip_pkg::CFG_TOLERANCE, 16'hFFFF);
    push_item(pip_pkg::ACT_QUERY, 0, 1280, 1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        3: cnt = 64;
        7: cnt = 127;
        default: cnt = $urandom_range(0, 12);
      endcase
      case (ph % 4)
        0: tol = pip_pkg::TOL_RESET;
        1: tol = '0;
        2: tol = 16'hFFFF;
        default: tol = (pip_pkg::TOL_W)'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 2))
        0: win_span = 1024;
        1: win_span = 65536;
        default: win_span = 4000000;
      endcase
      win_cx = longint'($signed($urandom) >>> 9);
      win_cy = longint'($signed($urandom) >>> 9);
      gen_n = (cnt > pip_pkg::MAX_VERTICES) ? pip_pkg::MAX_VERTICES : cnt;
      for (int s = 0; s < gen_n; s++)
        put_vertex(s, rnd_span(win_cx, win_span), rnd_span(win_cy, win_span));
      drain();
      cfg_write(pip_pkg::CFG_VERTEX_COUNT, (pip_pkg::CFG_DATA_W)'(cnt));
      cfg_write(pip_pkg::CFG_TOLERANCE, tol);
      nq = $urandom_range(18, 30);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(0, 11) == 0)
          put_vertex($urandom_range(0, 63), longint'($signed($urandom) >>> 8),
                     longint'($signed($urandom) >>> 8));
        push_query();
        if (q == nq / 2) drain();
      end
      drain();
      n_phases++;
    end

    drain();
    $display("Covered %0d phases: %0d vertex writes, %0d queries, %0d results checked",
             n_phases, n_writes, n_queries, n_checked);
    $display("Polygon sizes 0..64 plus saturated count, tolerance 0, 66, max and random");
    if (errors == 0) begin
      $display("point_in_polygon_test_top: match");
    end else begin
      $display("point_in_polygon_test_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timed out");
    $display("point_in_polygon_test_top: mismatch");
    $finish;
  end

endmodule
